[rtl/mma_pkg.sv]
// ----------------------------------------------------------------------------
// mma_pkg
// Shared constants for the matrix multiply-accumulate block: item kinds,
// field widths and binary32 patterns.
// ----------------------------------------------------------------------------
package mma_pkg;

  localparam int MMA_MATRIX_SIZE = 16;

  localparam int KIND_W  = 3;
  localparam int INDEX_W = 4;
  localparam int WORD_W  = 32;

  localparam logic [KIND_W-1:0] KIND_WRITE_A = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE_B = 3'd1;
  localparam logic [KIND_W-1:0] KIND_WRITE_Y = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MAC     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ_Y  = 3'd4;

  localparam logic [WORD_W-1:0] QNAN32 = 32'h7FC0_0000;
  localparam logic [WORD_W-1:0] INF32  = 32'h7F80_0000;

endpackage

[rtl/mma_fma.sv]
// ----------------------------------------------------------------------------
// mma_fma
// Multi-cycle binary32 fused multiply-add, a*b + c, one round to nearest
// even, subnormals kept. Normalization shifts by eight or one bit a cycle.
// ----------------------------------------------------------------------------
module mma_fma
  import mma_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WORD_W-1:0] a,
  input  logic [WORD_W-1:0] b,
  input  logic [WORD_W-1:0] c,
  output logic              done,
  output logic [WORD_W-1:0] result
);

  typedef enum logic [3:0] {
    F_IDLE, F_PREP, F_NORMP, F_NORMC, F_ALIGN, F_SHIFT, F_ADD, F_NORMM, F_ROUND
  } fstate_t;

  fstate_t            st;
  logic [WORD_W-1:0]  ra, rb, rc;
  logic [55:0]        pm, cm, big, little;
  logic signed [12:0] ep, ecx, e, d;
  logic               sp, sc, s, czero_r;
  logic [56:0]        mm;
  logic [5:0]         tt;

  logic [7:0]  ea, eb, ec;
  logic [22:0] fa, fb, fc;
  logic        ainf, binf, cinf, azero, bzero, czero, sa, sb;
  logic        spec;
  logic [WORD_W-1:0] sres;
  logic [23:0] ma, mb;
  logic [47:0] prod;
  logic        p_big;
  logic [63:0] small64, mask64, shifted;
  logic [56:0] sum;
  logic signed [12:0] be, rr;
  logic [63:0] mn64, q, rem, half, bits;
  logic [6:0]  r7;
  logic [WORD_W-1:0] rres;

  always_comb begin
    sa = ra[31];
    sb = rb[31];
    ea = ra[30:23];
    eb = rb[30:23];
    ec = rc[30:23];
    fa = ra[22:0];
    fb = rb[22:0];
    fc = rc[22:0];
    ainf = ea == 8'hFF;
    binf = eb == 8'hFF;
    cinf = ec == 8'hFF;
    azero = ea == 8'h00 && fa == 23'd0;
    bzero = eb == 8'h00 && fb == 23'd0;
    czero = ec == 8'h00 && fc == 23'd0;
    ma = {ea != 8'h00, fa};
    mb = {eb != 8'h00, fb};
    prod = ma * mb;
    spec = 1'b1;
    sres = '0;
    if ((ainf && fa != 23'd0) || (binf && fb != 23'd0) || (cinf && fc != 23'd0)) begin
      sres = QNAN32;
    end else if (ainf || binf) begin
      if (azero || bzero) begin
        sres = QNAN32;
      end else if (cinf && rc[31] != (sa ^ sb)) begin
        sres = QNAN32;
      end else begin
        sres = {sa ^ sb, INF32[30:0]};
      end
    end else if (cinf) begin
      sres = rc;
    end else if (azero || bzero) begin
      sres = czero ? {(sa ^ sb) & rc[31], 31'd0} : rc;
    end else begin
      spec = 1'b0;
    end
  end

  always_comb begin
    p_big = (ep > ecx) || (ep == ecx && pm >= cm);
    small64 = {8'd0, little};
    mask64 = (64'd1 << d[5:0]) - 64'd1;
    if (d >= 13'sd63) begin
      shifted = {63'd0, little != 56'd0};
    end else begin
      shifted = (small64 >> d[5:0]) | {63'd0, (small64 & mask64) != 64'd0};
    end
    sum = (sp == sc) ? ({1'b0, big} + {1'b0, shifted[55:0]})
                     : ({1'b0, big} - {1'b0, shifted[55:0]});
  end

  always_comb begin
    be = $signed({7'd0, tt}) + e + 13'sd127;
    if (be < 13'sd1) begin
      rr = 13'sd56 - $signed({7'd0, tt}) - 13'sd149 - e;
    end else begin
      rr = 13'sd33;
    end
    r7 = rr[6:0];
    mn64 = {7'd0, mm};
    rem = mn64 & ((64'd1 << r7[5:0]) - 64'd1);
    half = 64'd1 << (r7[5:0] - 6'd1);
    q = mn64 >> r7[5:0];
    if (rr >= 13'sd58) begin
      q = 64'd0;
    end else if (rem > half || (rem == half && q[0])) begin
      q = q + 64'd1;
    end
    if (be < 13'sd1) begin
      bits = q;
    end else begin
      bits = ({{51{be[12]}}, be - 13'sd1} << 23) + q;
      if (bits >= {32'd0, INF32}) begin
        bits = {32'd0, INF32};
      end
    end
    rres = {s, bits[30:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= F_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (st)
        F_IDLE: begin
          if (start) begin
            ra <= a;
            rb <= b;
            rc <= c;
            st <= F_PREP;
          end
        end
        F_PREP: begin
          if (spec) begin
            result <= sres;
            done <= 1'b1;
            st <= F_IDLE;
          end else begin
            pm <= {8'd0, prod};
            ep <= $signed({5'd0, (ea != 8'h00) ? ea : 8'd1})
                + $signed({5'd0, (eb != 8'h00) ? eb : 8'd1}) - 13'sd300;
            cm <= {32'd0, ec != 8'h00, fc};
            ecx <= $signed({5'd0, (ec != 8'h00) ? ec : 8'd1}) - 13'sd150;
            sp <= sa ^ sb;
            sc <= rc[31];
            czero_r <= czero;
            st <= F_NORMP;
          end
        end
        F_NORMP: begin
          if (pm[55:48] == 8'd0) begin
            pm <= pm << 8;
            ep <= ep - 13'sd8;
          end else if (!pm[55]) begin
            pm <= pm << 1;
            ep <= ep - 13'sd1;
          end else if (czero_r) begin
            mm <= {1'b0, pm};
            e <= ep;
            s <= sp;
            tt <= 6'd56;
            st <= F_NORMM;
          end else begin
            st <= F_NORMC;
          end
        end
        F_NORMC: begin
          if (cm[55:48] == 8'd0) begin
            cm <= cm << 8;
            ecx <= ecx - 13'sd8;
          end else if (!cm[55]) begin
            cm <= cm << 1;
            ecx <= ecx - 13'sd1;
          end else begin
            st <= F_ALIGN;
          end
        end
        F_ALIGN: begin
          if (p_big) begin
            big <= pm;
            little <= cm;
            e <= ep;
            s <= sp;
            d <= ep - ecx;
          end else begin
            big <= cm;
            little <= pm;
            e <= ecx;
            s <= sc;
            d <= ecx - ep;
          end
          st <= F_SHIFT;
        end
        F_SHIFT: begin
          st <= F_ADD;
        end
        F_ADD: begin
          if (sum == 57'd0) begin
            result <= '0;
            done <= 1'b1;
            st <= F_IDLE;
          end else begin
            mm <= sum;
            tt <= 6'd56;
            st <= F_NORMM;
          end
        end
        F_NORMM: begin
          if (mm[56:49] == 8'd0) begin
            mm <= mm << 8;
            tt <= tt - 6'd8;
          end else if (!mm[56]) begin
            mm <= mm << 1;
            tt <= tt - 6'd1;
          end else begin
            st <= F_ROUND;
          end
        end
        F_ROUND: begin
          result <= rres;
          done <= 1'b1;
          st <= F_IDLE;
        end
        default: st <= F_IDLE;
      endcase
    end
  end

endmodule

[rtl/matrix_multiply_accumulate_16x16.sv]
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate_16x16
// Binary32 Y = Y + A*B on MATRIX_SIZE square matrices, one shared fused
// multiply-add unit stepped by a small sequencer.
// ----------------------------------------------------------------------------
// Words write one element of A, B or Y, start a multiply-accumulate, or read
// one Y element. The block takes one word at a time and raises in_stall while
// it works. A read waits out any output stall. A multiply-accumulate runs
// MATRIX_SIZE^3 steps through the single fused multiply-add unit, the length
// of each step depending on special operands and how far the normalizing
// shifts travel, then returns one done word.
module matrix_multiply_accumulate_16x16
  import mma_pkg::*;
#(
  parameter int MATRIX_SIZE = MMA_MATRIX_SIZE
)
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [KIND_W-1:0]  kind,
  input  logic [INDEX_W-1:0] row,
  input  logic [INDEX_W-1:0] col,
  input  logic [WORD_W-1:0]  value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               is_done,
  output logic [INDEX_W-1:0] out_row,
  output logic [INDEX_W-1:0] out_col,
  output logic [WORD_W-1:0]  out_value
);

  localparam int CELLS = MATRIX_SIZE * MATRIX_SIZE;
  localparam int IDX_W = $clog2(CELLS);
  localparam int CNT_W = $clog2(MATRIX_SIZE);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(MATRIX_SIZE - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_ISSUE, S_FMA_GO, S_FMA_WAIT, S_READ, S_DONE
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   ci, cj, ck;
  logic [WORD_W-1:0]  mem_a [CELLS];
  logic [WORD_W-1:0]  mem_b [CELLS];
  logic [WORD_W-1:0]  mem_y [CELLS];
  logic [WORD_W-1:0]  a_q, b_q, y_q, acc;
  logic [IDX_W-1:0]   rd_idx;
  logic               rd_inside;
  logic [INDEX_W-1:0] rd_row, rd_col;

  logic               accept, in_range, out_free;
  logic [IDX_W-1:0]   in_idx, ij_idx, ik_idx, kj_idx, y_addr;
  logic               fma_start, fma_done;
  logic [WORD_W-1:0]  fma_c, fma_res;
  logic               y_we;
  logic [IDX_W-1:0]   y_waddr;
  logic [WORD_W-1:0]  y_wdata;

  assign in_stall = state != S_IDLE;
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign in_range = (32'(row) < MATRIX_SIZE) && (32'(col) < MATRIX_SIZE);
  assign in_idx   = IDX_W'(32'(row) * MATRIX_SIZE + 32'(col));
  assign ij_idx   = IDX_W'(32'(ci) * MATRIX_SIZE + 32'(cj));
  assign ik_idx   = IDX_W'(32'(ci) * MATRIX_SIZE + 32'(ck));
  assign kj_idx   = IDX_W'(32'(ck) * MATRIX_SIZE + 32'(cj));
  assign y_addr   = (state == S_IDLE) ? in_idx : ((state == S_READ) ? rd_idx : ij_idx);
  assign fma_start = state == S_FMA_GO;
  assign fma_c    = (ck == '0) ? y_q : acc;

  always_comb begin
    y_we = 1'b0;
    y_waddr = in_idx;
    y_wdata = value;
    if (accept && kind == KIND_WRITE_Y && in_range) begin
      y_we = 1'b1;
    end else if (state == S_FMA_WAIT && fma_done && ck == LAST) begin
      y_we = 1'b1;
      y_waddr = ij_idx;
      y_wdata = fma_res;
    end
  end

  mma_fma u_fma (
    .clk    (clk),
    .rst    (rst),
    .start  (fma_start),
    .a      (a_q),
    .b      (b_q),
    .c      (fma_c),
    .done   (fma_done),
    .result (fma_res)
  );

  always_ff @(posedge clk) begin
    if (accept && kind == KIND_WRITE_A && in_range) begin
      mem_a[in_idx] <= value;
    end
    a_q <= mem_a[ik_idx];
  end

  always_ff @(posedge clk) begin
    if (accept && kind == KIND_WRITE_B && in_range) begin
      mem_b[in_idx] <= value;
    end
    b_q <= mem_b[kj_idx];
  end

  always_ff @(posedge clk) begin
    if (y_we) begin
      mem_y[y_waddr] <= y_wdata;
    end
    y_q <= mem_y[y_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      ci <= '0;
      cj <= '0;
      ck <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && kind == KIND_MAC) begin
            ci <= '0;
            cj <= '0;
            ck <= '0;
            state <= S_ISSUE;
          end else if (accept && kind == KIND_READ_Y) begin
            rd_idx <= in_idx;
            rd_inside <= in_range;
            rd_row <= row;
            rd_col <= col;
            state <= S_READ;
          end
        end
        S_ISSUE: begin
          state <= S_FMA_GO;
        end
        S_FMA_GO: begin
          state <= S_FMA_WAIT;
        end
        S_FMA_WAIT: begin
          if (fma_done) begin
            acc <= fma_res;
            if (ck != LAST) begin
              ck <= ck + 1'b1;
              state <= S_ISSUE;
            end else begin
              ck <= '0;
              if (cj != LAST) begin
                cj <= cj + 1'b1;
                state <= S_ISSUE;
              end else begin
                cj <= '0;
                if (ci != LAST) begin
                  ci <= ci + 1'b1;
                  state <= S_ISSUE;
                end else begin
                  ci <= '0;
                  state <= S_DONE;
                end
              end
            end
          end
        end
        S_READ: begin
          if (out_free) begin
            out_valid <= 1'b1;
            is_done <= 1'b0;
            out_row <= rd_row;
            out_col <= rd_col;
            out_value <= rd_inside ? y_q : '0;
            state <= S_IDLE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            is_done <= 1'b1;
            out_row <= '0;
            out_col <= '0;
            out_value <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_mac_busy: assert property (@(posedge clk) disable iff (rst)
    accept && kind == KIND_MAC |=> in_stall)
    else $error("compute word did not start the sequencer");

  a_fma_done_wait: assert property (@(posedge clk) disable iff (rst)
    fma_done |-> state == S_FMA_WAIT)
    else $error("multiply-add result outside of wait");

  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_done |-> out_value == '0 && out_row == '0 && out_col == '0)
    else $error("done word carries data");
`endif

endmodule

[tb/tb_matrix_multiply_accumulate_16x16.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_matrix_multiply_accumulate_16x16
// Self-checking bench for the binary32 matrix multiply-accumulate block. It
// fills A, B and Y, mixes element writes, Y reads, unused kinds and full
// multiply-accumulates, predicts every returned word with a bit-exact fused
// multiply-add model, and runs under three sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_matrix_multiply_accumulate_16x16;
  import mma_pkg::*;

  localparam int N = MMA_MATRIX_SIZE;
  localparam int CELLS = N * N;
  localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;
  localparam int STALL_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 360;

  typedef struct packed {
    logic               done;
    logic [INDEX_W-1:0] r;
    logic [INDEX_W-1:0] c;
    logic [WORD_W-1:0]  v;
  } result_word_t;

  function automatic int msb_pos(longint unsigned x);
    int t;
    t = 0;
    while (t < 63 && (x >> (t + 1)) != 0) t++;
    return t;
  endfunction

  // fused a*b + c, one round to nearest even, subnormals kept
  function automatic logic [31:0] fused_mul_add(logic [31:0] a, logic [31:0] b,
                                                logic [31:0] c);
    logic sp, sc, s;
    logic [7:0] ea, eb, ec;
    logic [22:0] fa, fb, fc;
    bit ainf, binf, cinf, azero, bzero, czero;
    longint unsigned p, m, q, bits, cm, big, lil, rem, half;
    int ep, e, t, be, sh, ecx, d;
    sp = a[31] ^ b[31];
    sc = c[31];
    ea = a[30:23]; eb = b[30:23]; ec = c[30:23];
    fa = a[22:0];  fb = b[22:0];  fc = c[22:0];
    ainf = ea == 8'hFF; binf = eb == 8'hFF; cinf = ec == 8'hFF;
    azero = ea == 0 && fa == 0; bzero = eb == 0 && fb == 0; czero = ec == 0 && fc == 0;
    if ((ainf && fa != 0) || (binf && fb != 0) || (cinf && fc != 0)) return QNAN32;
    if (ainf || binf) begin
      if (azero || bzero) return QNAN32;
      if (cinf && sc != sp) return QNAN32;
      return {sp, 31'd0} | INF32;
    end
    if (cinf) return c;
    if (azero || bzero) begin
      if (czero) return {sp & sc, 31'd0};
      return c;
    end
    p = longint'({ea != 0, fa}) * longint'({eb != 0, fb});
    t = msb_pos(p);
    p = p << (55 - t);
    ep = (ea != 0 ? int'(ea) : 1) + (eb != 0 ? int'(eb) : 1) - 300 - (55 - t);
    if (czero) begin
      m = p; e = ep; s = sp;
    end else begin
      cm = longint'({ec != 0, fc});
      t = msb_pos(cm);
      cm = cm << (55 - t);
      ecx = (ec != 0 ? int'(ec) : 1) - 150 - (55 - t);
      if (ep > ecx || (ep == ecx && p >= cm)) begin
        big = p; lil = cm; e = ep; s = sp; d = ep - ecx;
      end else begin
        big = cm; lil = p; e = ecx; s = sc; d = ecx - ep;
      end
      if (d >= 63) lil = (lil != 0);
      else if (d > 0) lil = (lil >> d) | ((lil & ((64'd1 << d) - 1)) != 0);
      m = (sp == sc) ? big + lil : big - lil;
      if (m == 0) return 32'd0;
    end
    t = msb_pos(m);
    be = t + e + 127;
    sh = (be < 1) ? (-149 - e) : (t - 23);
    if (sh > 60) sh = 60;
    if (sh <= 0) begin
      q = m << (-sh);
    end else begin
      rem = m & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      q = m >> sh;
      if (rem > half || (rem == half && q[0])) q++;
    end
    if (be < 1) begin
      bits = q;
    end else begin
      bits = (longint'(be - 1) << 23) + q;
      if (bits >= INF32) bits = INF32;
    end
    return {s, bits[30:0]};
  endfunction

  class mac_scoreboard;
    logic [31:0] a_mat[CELLS];
    logic [31:0] b_mat[CELLS];
    logic [31:0] y_mat[CELLS];
    result_word_t pending[$];
    int errors, reads_seen, macs_seen;

    function new();
      errors = 0; reads_seen = 0; macs_seen = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    function void note_input(logic [KIND_W-1:0] k, logic [INDEX_W-1:0] r,
                             logic [INDEX_W-1:0] c, logic [WORD_W-1:0] v);
      int idx;
      logic [31:0] acc;
      idx = int'(r) * N + int'(c);
      case (k)
        KIND_WRITE_A: a_mat[idx] = v;
        KIND_WRITE_B: b_mat[idx] = v;
        KIND_WRITE_Y: y_mat[idx] = v;
        KIND_MAC: begin
          for (int i = 0; i < N; i++)
            for (int j = 0; j < N; j++) begin
              acc = y_mat[i * N + j];
              for (int kk = 0; kk < N; kk++)
                acc = fused_mul_add(a_mat[i * N + kk], b_mat[kk * N + j], acc);
              y_mat[i * N + j] = acc;
            end
          pending.push_back('{1'b1, '0, '0, '0});
        end
        KIND_READ_Y: pending.push_back('{1'b0, r, c, y_mat[idx]});
        default: ;
      endcase
    endfunction

    task check_result(result_word_t got);
      result_word_t exp_w;
      if (pending.size() == 0) begin
        report($sformatf("unexpected word done=%0b row=%0d col=%0d value=%h",
                         got.done, got.r, got.c, got.v));
        return;
      end
      exp_w = pending.pop_front();
      if (got.done) macs_seen++; else reads_seen++;
      if (got.done !== exp_w.done)
        report($sformatf("is_done %b, want %b", got.done, exp_w.done));
      if (got.r !== exp_w.r)
        report($sformatf("out_row %0d, want %0d", got.r, exp_w.r));
      if (got.c !== exp_w.c)
        report($sformatf("out_col %0d, want %0d", got.c, exp_w.c));
      if (got.v !== exp_w.v)
        report($sformatf("out_value %h, want %h (row %0d col %0d)",
                         got.v, exp_w.v, exp_w.r, exp_w.c));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [KIND_W-1:0] kind = '0;
  logic [INDEX_W-1:0] row = '0;
  logic [INDEX_W-1:0] col = '0;
  logic [WORD_W-1:0] value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic is_done;
  logic [INDEX_W-1:0] out_row;
  logic [INDEX_W-1:0] out_col;
  logic [WORD_W-1:0] out_value;

  mac_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int idle_cycles = 0;
  int words_sent = 0;

  matrix_multiply_accumulate_16x16 dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result('{is_done, out_row, out_col, out_value});
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no word moved in %0d cycles", STALL_LIMIT);
      $display("tb_matrix_multiply_accumulate_16x16 failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_word(logic [KIND_W-1:0] k, logic [INDEX_W-1:0] r,
                           logic [INDEX_W-1:0] c, logic [WORD_W-1:0] v);
    bit go;
    do begin
      @(negedge clk);
      go = $urandom_range(99) >= send_idle_pct;
      in_valid <= go;
    end while (!go);
    kind <= k; row <= r; col <= c; value <= v;
    do @(posedge clk); while (in_stall);
    sb.note_input(k, r, c, v);
    words_sent++;
  endtask

  function automatic logic [31:0] pick_float();
    int sel;
    logic [31:0] specials[10];
    specials = '{32'h0000_0000, 32'h8000_0000, INF32, 32'hFF80_0000, QNAN32,
                 32'h7F80_0001, 32'h0000_0001, 32'h807F_FFFF, 32'h7F7F_FFFF,
                 32'h0080_0000};
    sel = $urandom_range(99);
    if (sel < 8) return specials[$urandom_range(9)];
    if (sel < 20) return $urandom();
    return {1'($urandom_range(1)), 8'($urandom_range(140, 112)), 23'($urandom())};
  endfunction

  task automatic fill_all();
    for (int i = 0; i < CELLS; i++) begin
      send_word(KIND_WRITE_A, INDEX_W'(i / N), INDEX_W'(i % N), pick_float());
      send_word(KIND_WRITE_B, INDEX_W'(i / N), INDEX_W'(i % N), pick_float());
      send_word(KIND_WRITE_Y, INDEX_W'(i / N), INDEX_W'(i % N), pick_float());
    end
  endtask

  task automatic random_phase(int items);
    int sel;
    for (int n = 0; n < items; n++) begin
      sel = $urandom_range(99);
      if (n == items / 3 || n == (2 * items) / 3)
        send_word(KIND_MAC, INDEX_W'($urandom()), INDEX_W'($urandom()), $urandom());
      else if (sel < 45)
        send_word(3'($urandom_range(KIND_WRITE_Y, KIND_WRITE_A)), INDEX_W'($urandom()),
                  INDEX_W'($urandom()), pick_float());
      else if (sel < 95)
        send_word(KIND_READ_Y, INDEX_W'($urandom()), INDEX_W'($urandom()), $urandom());
      else
        send_word(3'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST)),
                  INDEX_W'($urandom()), INDEX_W'($urandom()), $urandom());
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // corners before the full fill: touched Y cells only, spare kinds
    send_word(KIND_WRITE_Y, '0, '0, 32'hFFFF_FFFF);
    send_word(KIND_WRITE_Y, INDEX_W'(N - 1), INDEX_W'(N - 1), 32'h0000_0000);
    send_word(KIND_WRITE_Y, '0, INDEX_W'(N - 1), 32'h8000_0001);
    send_word(KIND_READ_Y, '0, '0, 32'hFFFF_FFFF);
    send_word(KIND_READ_Y, INDEX_W'(N - 1), INDEX_W'(N - 1), 32'h0);
    send_word(KIND_READ_Y, '0, INDEX_W'(N - 1), 32'h0);
    for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++)
      send_word(3'(k), INDEX_W'(N - 1), '0, 32'hFFFF_FFFF);
    send_word(KIND_WRITE_Y, INDEX_W'(N - 1), '0, INF32);
    send_word(KIND_READ_Y, INDEX_W'(N - 1), '0, 32'h0);

    send_idle_pct = 11; recv_idle_pct = 57;
    fill_all();
    random_phase(PHASE_ITEMS);
    send_idle_pct = 57; recv_idle_pct = 11;
    random_phase(PHASE_ITEMS);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(PHASE_ITEMS);

    @(negedge clk);
    in_valid <= 1'b0;
    wait (sb.pending.size() == 0);
    repeat (40) @(posedge clk);

    $display("sent %0d words; checked %0d Y reads and %0d multiply-accumulates",
             words_sent, sb.reads_seen, sb.macs_seen);
    $display("three idling mixes covered, %0d mismatches", sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_matrix_multiply_accumulate_16x16 passed");
    else
      $display("tb_matrix_multiply_accumulate_16x16 failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/mma_pkg.sv
rtl/mma_fma.sv
rtl/matrix_multiply_accumulate_16x16.sv
tb/tb_matrix_multiply_accumulate_16x16.sv
